// ----- hdl/rqs_pkg.sv -----
package rqs_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  localparam logic OP_ENQ  = 1'b0;
  localparam logic OP_DISP = 1'b1;

  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] process_id;
    logic [7:0]  priority_req;
    logic [15:0] burst;
  } rqs_req_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] chosen_id;
    logic [15:0] run_time;
    logic        preempted;
    logic        dropped;
    logic [4:0]  occupancy;
  } rqs_rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] rem;
  } slot_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic [IDX_W-1:0] idx;
  } pick_ctl_t;

endpackage

// ----- hdl/rqs_slot_ram.sv -----
module rqs_slot_ram
  import rqs_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  slot_t            wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output slot_t            rdata_o
);

  slot_t mem [DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rqs_picker.sv -----
module rqs_picker
  import rqs_pkg::*;
(
  input  logic             clk_i,
  input  pick_ctl_t        ctl_i,
  input  logic [1:0]       policy_i,
  input  slot_t            entry_i,
  output slot_t            best_o,
  output logic [IDX_W-1:0] best_idx_o
);

  slot_t            best_q, best_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [15:0]      key_new, key_best;
  logic             take;

  always_comb begin
    key_new  = 16'd0;
    key_best = 16'd0;
    case (policy_i)
      POL_SJF: begin
        key_new  = entry_i.rem;
        key_best = best_q.rem;
      end
      POL_PRIO: begin
        key_new  = {8'd0, entry_i.prio};
        key_best = {8'd0, best_q.prio};
      end
      default: begin
        key_new  = 16'd0;
        key_best = 16'd0;
      end
    endcase
    take       = ctl_i.valid && (ctl_i.first || (key_new < key_best));
    best_d     = take ? entry_i : best_q;
    best_idx_d = take ? ctl_i.idx : best_idx_q;
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
  end

  assign best_o     = best_q;
  assign best_idx_o = best_idx_q;

endmodule

// ----- hdl/ready_queue_scheduler.sv -----
// Ready queue of up to 16 jobs kept in arrival order. A request is taken when start is
// high and busy is low; its result shows on rsp_o for exactly one cycle with done_o
// high, and must be captured then. An enqueue, or a dispatch on an empty queue, is
// answered the next cycle and busy stays low. A dispatch on n queued jobs scans all n
// entries through the single read port of the slot memory, then shifts the m entries
// behind the chosen one down through the same port, then finishes; the result shows
// on rsp_o as busy falls. Policy and quantum are to be written by the user only while
// the block is idle; the block itself does not enforce this.
module ready_queue_scheduler
  import rqs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  rqs_req_t    req_i,
  output logic        done_o,
  output rqs_rsp_t    rsp_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_SHIFT  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [1:0]       policy_q;
  logic [15:0]      quantum_q;
  logic             done_q, done_d;
  rqs_rsp_t         rsp_q, rsp_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_t            ram_wdata, ram_rdata;
  pick_ctl_t        pick_ctl;
  slot_t            best;
  logic [IDX_W-1:0] best_idx;
  logic [15:0]      q_eff;
  logic             accept;

  rqs_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rqs_picker u_picker (
    .clk_i      (clk_i),
    .ctl_i      (pick_ctl),
    .policy_i   (policy_q),
    .entry_i    (ram_rdata),
    .best_o     (best),
    .best_idx_o (best_idx)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign q_eff  = (quantum_q == 16'd0) ? 16'd1 : quantum_q;

  always_comb begin
    pick_ctl.valid = pend_q && (state_q == ST_SCAN);
    pick_ctl.first = (pend_idx_q == '0);
    pick_ctl.idx   = pend_idx_q;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = rd_ptr_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rsp_d = '0;
          if (req_i.op == OP_ENQ) begin
            done_d = 1'b1;
            if (count_q == CNT_W'(DEPTH)) begin
              rsp_d.dropped = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[IDX_W-1:0];
              ram_wdata = '{id: req_i.process_id, prio: req_i.priority_req,
                            rem: req_i.burst};
              count_d   = count_q + 1'b1;
            end
            rsp_d.occupancy = 5'(count_d);
          end else if (count_q == '0) begin
            done_d = 1'b1;
          end else begin
            rd_ptr_d = '0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_ptr_q < count_q) begin
          ram_re     = 1'b1;
          rd_ptr_d   = rd_ptr_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[IDX_W-1:0];
        end else if (!pend_q) begin
          rd_ptr_d = {1'b0, best_idx} + 1'b1;
          state_d  = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (rd_ptr_q < count_q) begin
          ram_re     = 1'b1;
          rd_ptr_d   = rd_ptr_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[IDX_W-1:0];
        end else if (!pend_q) begin
          state_d = ST_FINISH;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q - 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      ST_FINISH: begin
        done_d          = 1'b1;
        rsp_d           = '0;
        rsp_d.granted   = 1'b1;
        rsp_d.chosen_id = best.id;
        state_d         = ST_IDLE;
        if (policy_q == POL_RR && best.rem > q_eff) begin
          rsp_d.run_time  = q_eff;
          rsp_d.preempted = 1'b1;
          ram_we          = 1'b1;
          ram_waddr       = count_q[IDX_W-1:0] - 1'b1;
          ram_wdata       = '{id: best.id, prio: best.prio, rem: best.rem - q_eff};
        end else begin
          rsp_d.run_time = best.rem;
          count_d        = count_q - 1'b1;
        end
        rsp_d.occupancy = 5'(count_d);
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_ptr_q  <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
      policy_q  <= POL_FIFO;
      quantum_q <= 16'd1;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POLICY:  policy_q  <= cfg_data_i[1:0];
          REG_QUANTUM: quantum_q <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    rsp_q      <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("job count above depth");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q != '0))
    else $error("scan on empty queue");

  a_grant_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(rsp_q.granted && rsp_q.dropped))
    else $error("request both granted and dropped");

  a_preempt_rr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.preempted) |-> (rsp_q.granted && policy_q == POL_RR))
    else $error("preemption outside round robin");

  a_dispatch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.op == OP_DISP && count_q != '0) |=> (busy && !done_q))
    else $error("dispatch did not start scan");

endmodule
